// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define SMCE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define SMCE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/smce_pkg.sv =====
// Types and constants of the softmax cross-entropy loss and gradient block.
package smce_pkg;

  localparam int CFG_W      = 11;
  localparam int PROB_W     = 16;
  localparam int LABEL_W    = 11;
  localparam int GRAD_W     = 17;
  localparam int LOSS_W     = 20;
  localparam int SUM_W      = 30;
  localparam int STEP_W     = 5;
  localparam int LOG_STEPS  = 20;
  localparam int FRAC_W     = 20;
  localparam int LQ_W       = 25;
  localparam int X_W        = 31;
  localparam int MUL_W      = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 2;

  localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [GRAD_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [ADDR_W-1:0] REG_NUM_CLASSES = 2'd0;
  localparam logic [ADDR_W-1:0] REG_BATCH_SIZE  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_TRAIN_MODE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_MEAN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_SQR,
    LG_MUL,
    LG_RND
  } log_st_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [CFG_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ===== src/smce_log.sv =====
// -ln(p) in Q.16 by repeated squaring on one shared 32x32 multiplier.
module smce_log (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [smce_pkg::PROB_W-1:0]  prob,
  output logic                         busy,
  output logic [smce_pkg::LOSS_W-1:0]  neg_ln
);

  smce_pkg::log_st_t st_r, st_nxt;
  logic [smce_pkg::X_W-1:0]    x_r, x_nxt;
  logic [smce_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic [3:0]                  n_r, n_nxt;
  logic [smce_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]                 prod_r, prod_nxt;
  logic [smce_pkg::LOSS_W-1:0] res_r, res_nxt;

  logic [smce_pkg::MUL_W-1:0]  op_a, op_b;
  logic [63:0]                 prod;
  logic [smce_pkg::MUL_W-1:0]  sq;
  logic [smce_pkg::PROB_W-1:0] pp, mant;
  logic [3:0]                  lead;
  logic [smce_pkg::LQ_W-1:0]   lq;
  logic [4:0]                  ipart;

  always_comb begin
    pp   = (prob == '0) ? smce_pkg::PROB_W'(1) : prob;
    lead = 4'd0;
    for (int i = 0; i < smce_pkg::PROB_W; i++) begin
      if (pp[i]) lead = 4'(i);
    end
    mant = smce_pkg::PROB_W'(pp << (4'd15 - lead));
  end

  assign ipart = 5'd16 - {1'b0, n_r};
  assign lq    = {ipart, 20'd0} - {5'd0, frac_r};
  assign op_a  = (st_r == smce_pkg::LG_MUL) ? smce_pkg::MUL_W'(lq) : {1'b0, x_r};
  assign op_b  = (st_r == smce_pkg::LG_MUL) ? smce_pkg::LN2_Q32 : {1'b0, x_r};
  assign prod  = 64'(op_a) * 64'(op_b);
  assign sq    = prod[61:30];

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    frac_nxt = frac_r;
    n_nxt    = n_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    res_nxt  = res_r;
    unique case (st_r)
      smce_pkg::LG_IDLE: begin
        if (start) begin
          x_nxt    = {mant, 15'd0};
          n_nxt    = lead;
          frac_nxt = '0;
          cnt_nxt  = smce_pkg::STEP_W'(smce_pkg::LOG_STEPS);
          st_nxt   = smce_pkg::LG_SQR;
        end
      end
      smce_pkg::LG_SQR: begin
        if (sq[31]) begin
          x_nxt    = sq[31:1];
          frac_nxt = {frac_r[smce_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          x_nxt    = sq[30:0];
          frac_nxt = {frac_r[smce_pkg::FRAC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - smce_pkg::STEP_W'(1);
        if (cnt_r == smce_pkg::STEP_W'(1)) st_nxt = smce_pkg::LG_MUL;
      end
      smce_pkg::LG_MUL: begin
        prod_nxt = prod;
        st_nxt   = smce_pkg::LG_RND;
      end
      smce_pkg::LG_RND: begin
        res_nxt = smce_pkg::LOSS_W'((prod_r + 64'h8_0000_0000) >> 36);
        st_nxt  = smce_pkg::LG_IDLE;
      end
      default: st_nxt = smce_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= smce_pkg::LG_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    frac_r <= frac_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign busy   = (st_r != smce_pkg::LG_IDLE);
  assign neg_ln = res_r;

endmodule

// ===== src/smce_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
module smce_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  smce_pkg::div_req_t          req,
  output logic                        busy,
  output logic [smce_pkg::SUM_W-1:0]  quot
);

  logic                        busy_r, busy_nxt;
  logic [smce_pkg::SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [smce_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [smce_pkg::CFG_W-1:0]  d_r, d_nxt;
  logic [smce_pkg::CFG_W-1:0]  rem_r, rem_nxt;
  logic [smce_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [smce_pkg::CFG_W:0]    trial;
  logic                        fits;

  assign trial = {rem_r, dvd_r[smce_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_comb begin
    busy_nxt = busy_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      rem_nxt = fits ? smce_pkg::CFG_W'(trial - {1'b0, d_r}) : trial[smce_pkg::CFG_W-1:0];
      q_nxt   = {q_r[smce_pkg::SUM_W-2:0], fits};
      dvd_nxt = {dvd_r[smce_pkg::SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - smce_pkg::STEP_W'(1);
      if (cnt_r == smce_pkg::STEP_W'(1)) busy_nxt = 1'b0;
    end else if (req.start) begin
      busy_nxt = 1'b1;
      dvd_nxt  = req.dividend;
      d_nxt    = req.divisor;
      cnt_nxt  = req.steps;
      rem_nxt  = '0;
      q_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== src/softmax_cross_entropy_loss_grad.sv =====
// Top level: sparse softmax cross-entropy loss and gradient sequencer.
//
//  channel | dir | fields (low bit first)
//  in_     | in  | tdata: prob[15:0], label[26:16]
//  out_    | out | tdata: grad[16:0], mean_loss[36:17]; tlast: loss_valid;
//          |     | tuser: label_error
//  cfg_    | in  | addr 0 num_classes, 1 batch_size, 2 train_mode
//
//  Labelled element: 20 squaring steps, multiply, round; in train mode the 17-step
//  gradient division runs beside them. Others wait only for that division, in train mode.
//  The last element of a batch adds the 30-step loss division.
//  in_tready is high only while the sequencer is idle; a finished result waits in the
//  output register and stalls the sequencer only if the previous one is still there.
//  rst_n is synchronous, active low; control and config registers return to reset values.
`include "assert_macros.svh"

module softmax_cross_entropy_loss_grad #(
  parameter int MAX_CLASSES = 1024,
  parameter int MAX_BATCH   = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [smce_pkg::IN_DATA_W-1:0]   in_tdata,   // prob, label
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [smce_pkg::OUT_DATA_W-1:0]  out_tdata,  // grad, mean_loss
  output logic                             out_tlast,
  output logic                             out_tuser,  // label_error
  input  logic                             cfg_we,
  input  logic [smce_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [smce_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int RW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CMP_W = 18;
  localparam int MAXC_CLIP = (MAX_CLASSES > 2047) ? 2047 : MAX_CLASSES;
  localparam int MAXB_CLIP = (MAX_BATCH > 2047) ? 2047 : MAX_BATCH;
  localparam logic [smce_pkg::CFG_W-1:0] MAXC = smce_pkg::CFG_W'(MAXC_CLIP);
  localparam logic [smce_pkg::CFG_W-1:0] MAXB = smce_pkg::CFG_W'(MAXB_CLIP);

  smce_pkg::state_t st_r, st_nxt;

  logic [smce_pkg::CFG_W-1:0]  ncls_cfg_r, nbat_cfg_r;
  logic                        train_r;
  logic [CW-1:0]               cls_cnt_r, cls_cnt_nxt;
  logic [RW-1:0]               row_cnt_r, row_cnt_nxt;
  logic [smce_pkg::SUM_W-1:0]  loss_sum_r, loss_sum_nxt;
  logic                        err_seen_r, err_seen_nxt;

  logic                        hit_r, hit_nxt;
  logic                        err_r, err_nxt;
  logic                        row_end_r, row_end_nxt;
  logic                        bend_r, bend_nxt;
  logic                        tr_r, tr_nxt;
  logic [smce_pkg::GRAD_W-1:0] grad_r, grad_nxt;
  logic [smce_pkg::LOSS_W-1:0] mean_r, mean_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [smce_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_user_r, out_user_nxt;

  logic [smce_pkg::CFG_W-1:0]  nc, nb;
  logic [smce_pkg::PROB_W-1:0] prob;
  logic [smce_pkg::LABEL_W-1:0] label;
  logic                        accept, lab_ok, hit, row_end, emit_go;
  logic [smce_pkg::GRAD_W-1:0] dvd17;
  logic [smce_pkg::SUM_W-1:0]  loss_new;

  logic                        lg_start, lg_busy;
  logic [smce_pkg::LOSS_W-1:0] lg_res;
  smce_pkg::div_req_t          dv_req;
  logic                        dv_busy;
  logic [smce_pkg::SUM_W-1:0]  dv_quot;

  smce_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lg_start),
    .prob   (prob),
    .busy   (lg_busy),
    .neg_ln (lg_res)
  );

  smce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .busy  (dv_busy),
    .quot  (dv_quot)
  );

  assign nc = (ncls_cfg_r == '0) ? smce_pkg::CFG_W'(1) :
              ((ncls_cfg_r > MAXC) ? MAXC : ncls_cfg_r);
  assign nb = (nbat_cfg_r == '0) ? smce_pkg::CFG_W'(1) :
              ((nbat_cfg_r > MAXB) ? MAXB : nbat_cfg_r);

  assign prob    = in_tdata[15:0];
  assign label   = in_tdata[26:16];
  assign in_tready = (st_r == smce_pkg::ST_IDLE);
  assign accept  = in_tvalid && in_tready;
  assign lab_ok  = !label[smce_pkg::LABEL_W-1] && (label < nc);
  assign hit     = lab_ok && (CMP_W'(label) == CMP_W'(cls_cnt_r));
  assign row_end = (CMP_W'(cls_cnt_r) + CMP_W'(1)) >= CMP_W'(nc);
  assign dvd17   = hit ? (smce_pkg::ONE_Q16 - {1'b0, prob}) : {1'b0, prob};
  assign loss_new = hit_r ? smce_pkg::SUM_W'(loss_sum_r + smce_pkg::SUM_W'(lg_res))
                          : loss_sum_r;

  always_comb begin
    st_nxt       = st_r;
    cls_cnt_nxt  = cls_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    loss_sum_nxt = loss_sum_r;
    err_seen_nxt = err_seen_r;
    hit_nxt      = hit_r;
    err_nxt      = err_r;
    row_end_nxt  = row_end_r;
    bend_nxt     = bend_r;
    tr_nxt       = tr_r;
    grad_nxt     = grad_r;
    mean_nxt     = mean_r;
    lg_start     = 1'b0;
    dv_req       = '0;
    dv_req.divisor = nb;
    emit_go      = 1'b0;
    unique case (st_r)
      smce_pkg::ST_IDLE: begin
        if (accept) begin
          hit_nxt     = hit;
          err_nxt     = err_seen_r || !lab_ok;
          row_end_nxt = row_end;
          bend_nxt    = row_end && ((CMP_W'(row_cnt_r) + CMP_W'(1)) >= CMP_W'(nb));
          tr_nxt      = train_r;
          lg_start    = hit;
          dv_req.start    = train_r;
          dv_req.dividend = {dvd17, 13'd0};
          dv_req.steps    = smce_pkg::STEP_W'(smce_pkg::GRAD_W);
          st_nxt      = smce_pkg::ST_CALC;
        end
      end
      smce_pkg::ST_CALC: begin
        if (!lg_busy && !dv_busy) begin
          if (!tr_r) grad_nxt = '0;
          else if (hit_r) grad_nxt = smce_pkg::GRAD_W'(0) - dv_quot[smce_pkg::GRAD_W-1:0];
          else grad_nxt = dv_quot[smce_pkg::GRAD_W-1:0];
          st_nxt = smce_pkg::ST_ACC;
        end
      end
      smce_pkg::ST_ACC: begin
        loss_sum_nxt = loss_new;
        if (bend_r) begin
          dv_req.start    = 1'b1;
          dv_req.dividend = loss_new;
          dv_req.steps    = smce_pkg::STEP_W'(smce_pkg::SUM_W);
          st_nxt = smce_pkg::ST_MEAN;
        end else begin
          mean_nxt = '0;
          st_nxt   = smce_pkg::ST_EMIT;
        end
      end
      smce_pkg::ST_MEAN: begin
        if (!dv_busy) begin
          mean_nxt = (dv_quot[smce_pkg::SUM_W-1:smce_pkg::LOSS_W] != '0) ? '1 :
                     dv_quot[smce_pkg::LOSS_W-1:0];
          st_nxt = smce_pkg::ST_EMIT;
        end
      end
      smce_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit_go = 1'b1;
          if (bend_r) begin
            cls_cnt_nxt  = '0;
            row_cnt_nxt  = '0;
            loss_sum_nxt = '0;
            err_seen_nxt = 1'b0;
          end else if (row_end_r) begin
            cls_cnt_nxt  = '0;
            row_cnt_nxt  = row_cnt_r + RW'(1);
            err_seen_nxt = err_r;
          end else begin
            cls_cnt_nxt  = cls_cnt_r + CW'(1);
            err_seen_nxt = err_r;
          end
          st_nxt = smce_pkg::ST_IDLE;
        end
      end
      default: st_nxt = smce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, mean_r, grad_r};
      out_last_nxt  = bend_r;
      out_user_nxt  = err_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= smce_pkg::ST_IDLE;
      ncls_cfg_r  <= smce_pkg::CFG_W'(1);
      nbat_cfg_r  <= smce_pkg::CFG_W'(1);
      train_r     <= 1'b1;
      cls_cnt_r   <= '0;
      row_cnt_r   <= '0;
      loss_sum_r  <= '0;
      err_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cls_cnt_r   <= cls_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      loss_sum_r  <= loss_sum_nxt;
      err_seen_r  <= err_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          smce_pkg::REG_NUM_CLASSES: ncls_cfg_r <= cfg_wdata;
          smce_pkg::REG_BATCH_SIZE:  nbat_cfg_r <= cfg_wdata;
          smce_pkg::REG_TRAIN_MODE:  train_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    err_r      <= err_nxt;
    row_end_r  <= row_end_nxt;
    bend_r     <= bend_nxt;
    tr_r       <= tr_nxt;
    grad_r     <= grad_nxt;
    mean_r     <= mean_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `SMCE_ASSERT(a_busy_blocks_in, clk, rst_n, (lg_busy || dv_busy) |-> !in_tready, "input taken while a unit is busy")
  `SMCE_ASSERT(a_accept_closes, clk, rst_n, accept |=> !in_tready, "sequencer did not leave idle after a transaction")
  `SMCE_ASSERT(a_emit_shows, clk, rst_n, emit_go |=> out_tvalid, "result not presented after emit")
  `SMCE_ASSERT(a_div_free, clk, rst_n, dv_req.start |-> !dv_busy, "divider started while busy")

endmodule

// ===== verif/softmax_cross_entropy_loss_grad_tb.sv =====
// Self-checking testbench for the softmax cross-entropy loss and gradient block.
module softmax_cross_entropy_loss_grad_tb;

  localparam int MAX_CLASSES = 1024;
  localparam int MAX_BATCH   = 1024;
  localparam longint unsigned LN2_Q32_FIX = 64'd2977044472;

  typedef struct packed {
    logic [10:0] label;
    logic [15:0] prob;
  } elem_t;

  typedef struct packed {
    logic [16:0] grad;
    logic [19:0] mean_loss;
    logic        loss_valid;
    logic        label_error;
  } loss_grad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [smce_pkg::IN_DATA_W-1:0] in_tdata = '0;    // prob[15:0], label[26:16]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [smce_pkg::OUT_DATA_W-1:0] out_tdata;       // grad[16:0], mean_loss[36:17]
  logic out_tlast;
  logic out_tuser;                                  // label_error
  logic cfg_we = 1'b0;
  logic [smce_pkg::ADDR_W-1:0] cfg_addr = '0;
  logic [smce_pkg::CFG_W-1:0] cfg_wdata = '0;

  elem_t      pending_elems[$];
  loss_grad_t grad_loss_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  bit hold_req = 1'b0;
  logic hold_off = 1'b0;

  // predictor copy of the registers and state
  logic [10:0] cfg_classes = 11'd1;
  logic [10:0] cfg_batch = 11'd1;
  logic        cfg_train = 1'b1;
  int unsigned cls_idx = 0;
  int unsigned row_idx = 0;
  logic [29:0] loss_acc = '0;
  bit          err_sticky = 1'b0;

  softmax_cross_entropy_loss_grad #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_BATCH  (MAX_BATCH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_count(input logic [10:0] v, input int unsigned hi);
    if (v == 11'd0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // -ln(p) in Q.16 via log2 by repeated squaring
  function automatic logic [31:0] neg_ln_q16(input logic [15:0] p);
    logic [15:0] v;
    logic [15:0] mant;
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] lq;
    int msb;
    v = (p == 16'd0) ? 16'd1 : p;
    msb = 15;
    while (!v[msb]) msb--;
    mant = v << (15 - msb);
    x = {48'd0, mant} << 15;
    frac = '0;
    for (int i = 0; i < 20; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    lq = (64'(16 - msb) << 20) - frac;
    return 32'((lq * LN2_Q32_FIX + (64'd1 << 35)) >> 36);
  endfunction

  task automatic loss_grad_step(input logic [15:0] p, input logic [10:0] lab_raw);
    loss_grad_t r;
    int unsigned nc;
    int unsigned nb;
    int unsigned mag;
    int unsigned avg;
    int lab;
    bit ok;
    bit hit;
    bit row_end;
    bit batch_end;
    nc = eff_count(cfg_classes, MAX_CLASSES);
    nb = eff_count(cfg_batch, MAX_BATCH);
    lab = int'($signed(lab_raw));
    ok = (lab >= 0) && (lab < int'(nc));
    if (!ok) err_sticky = 1'b1;
    hit = ok && (lab == int'(cls_idx));
    if (hit) loss_acc = 30'(loss_acc + neg_ln_q16(p));
    r = '0;
    if (cfg_train) begin
      if (hit) begin
        mag = (32'd65536 - p) / nb;
        r.grad = 17'(32'd0 - mag);
      end else begin
        r.grad = 17'(p / nb);
      end
    end
    r.label_error = err_sticky;
    row_end = (cls_idx + 1) >= nc;
    batch_end = row_end && ((row_idx + 1) >= nb);
    if (batch_end) begin
      avg = loss_acc / nb;
      r.mean_loss = (avg > 32'hFFFFF) ? 20'hFFFFF : 20'(avg);
      r.loss_valid = 1'b1;
      cls_idx = 0;
      row_idx = 0;
      loss_acc = '0;
      err_sticky = 1'b0;
    end else if (row_end) begin
      cls_idx = 0;
      row_idx++;
    end else begin
      cls_idx++;
    end
    grad_loss_due.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin : drive_elems
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        loss_grad_step(in_tdata[15:0], in_tdata[26:16]);
        void'(pending_elems.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, pending_elems[0].label, pending_elems[0].prob};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    loss_grad_t got;
    loss_grad_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.grad = out_tdata[16:0];
        got.mean_loss = out_tdata[36:17];
        got.loss_valid = out_tlast;
        got.label_error = out_tuser;
        if (grad_loss_due.size() == 0) begin
          $error("unexpected result transaction: grad %0d", $signed(got.grad));
          mismatches++;
        end else begin
          want = grad_loss_due.pop_front();
          if (got.grad !== want.grad) begin
            $error("grad: expected %0d, got %0d", $signed(want.grad), $signed(got.grad));
            mismatches++;
          end
          if (got.mean_loss !== want.mean_loss) begin
            $error("mean_loss: expected %0d, got %0d", want.mean_loss, got.mean_loss);
            mismatches++;
          end
          if (got.loss_valid !== want.loss_valid) begin
            $error("loss_valid: expected %0d, got %0d", want.loss_valid, got.loss_valid);
            mismatches++;
          end
          if (got.label_error !== want.label_error) begin
            $error("label_error: expected %0d, got %0d", want.label_error, got.label_error);
            mismatches++;
          end
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic write_reg(input logic [1:0] addr, input logic [10:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      smce_pkg::REG_NUM_CLASSES: cfg_classes = value;
      smce_pkg::REG_BATCH_SIZE:  cfg_batch = value;
      smce_pkg::REG_TRAIN_MODE:  cfg_train = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [10:0] classes, input logic [10:0] batch,
                            input logic train);
    write_reg(smce_pkg::REG_NUM_CLASSES, classes);
    write_reg(smce_pkg::REG_BATCH_SIZE, batch);
    write_reg(smce_pkg::REG_TRAIN_MODE, {10'd0, train});
  endtask

  task automatic push_elem(input logic [15:0] p, input logic [10:0] lab);
    elem_t e;
    e.prob = p;
    e.label = lab;
    pending_elems.push_back(e);
  endtask

  task automatic settle();
    while (pending_elems.size() != 0 || in_tvalid || grad_loss_due.size() != 0)
      @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1 << $urandom_range(15);
      3: return 16'($urandom_range(255, 1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // well-formed rows with random content, some bad labels and stray labels
  task automatic queue_rows(input int total);
    int sent;
    int nc;
    int lab;
    int len;
    sent = 0;
    nc = eff_count(cfg_classes, MAX_CLASSES);
    len = (cls_idx < nc) ? nc - cls_idx : 1;
    while (sent < total) begin
      if ($urandom_range(9) != 0) lab = $urandom_range(nc - 1);
      else if (nc < 1024 && $urandom_range(1)) lab = $urandom_range(1023, nc);
      else lab = $urandom_range(2047, 1024);
      for (int k = 0; k < len && sent < total; k++) begin
        push_elem(rand_prob(), ($urandom_range(19) == 0) ? 11'($urandom_range(2047)) : 11'(lab));
        sent++;
      end
      len = nc;
    end
  endtask

  initial begin
    logic [10:0] classes;
    logic [10:0] batch;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration: one class, one row
    push_elem(16'd0, 11'd0);
    push_elem(16'hFFFF, 11'd0);
    settle();

    set_config(11'd4, 11'd2, 1'b1);
    push_elem(16'd0, 11'd0);
    push_elem(16'hFFFF, 11'd0);
    push_elem(16'd1, 11'd0);
    push_elem(16'h8000, 11'd0);
    push_elem(16'hFFFF, 11'd3);
    push_elem(16'd0, 11'd3);
    push_elem(16'd40000, 11'd3);
    push_elem(16'hFFFF, 11'd3);
    // label equal to class count, then label changing within a row
    push_elem(16'd100, 11'd4);
    push_elem(16'd200, 11'd4);
    push_elem(16'd300, 11'd4);
    push_elem(16'd400, 11'd4);
    push_elem(16'd5, 11'd2);
    push_elem(16'd6, 11'd1);
    push_elem(16'd7, 11'h400);
    push_elem(16'd8, 11'h7FF);
    settle();

    // loss-only mode, accumulate, then shrink the batch so the mean saturates
    set_config(11'd1, 11'd8, 1'b0);
    repeat (4) push_elem(16'd0, 11'd0);
    settle();
    write_reg(smce_pkg::REG_BATCH_SIZE, 11'd1);
    push_elem(16'd0, 11'd0);
    settle();

    // zero registers act as one
    set_config(11'd0, 11'd0, 1'b1);
    push_elem(16'h8000, 11'd0);
    push_elem(16'd1234, 11'd1023);
    settle();

    set_config(11'd1024, 11'd1024, 1'b1);
    push_elem(16'hABCD, 11'd0);
    push_elem(16'h5432, 11'd1);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(9))
        0: classes = 11'd1;
        1: classes = 11'd2;
        2: classes = 11'd1024;
        3: classes = 11'd0;
        4: classes = 11'd2047;
        default: classes = 11'($urandom_range(12, 3));
      endcase
      case ($urandom_range(7))
        0: batch = 11'd1;
        1: batch = 11'd1024;
        2: batch = 11'd0;
        3: batch = 11'd2047;
        default: batch = 11'($urandom_range(6, 2));
      endcase
      set_config(classes, batch, $urandom_range(3) != 0);
      @(negedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      queue_rows(150);
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/smce_pkg.sv
src/smce_log.sv
src/smce_div.sv
src/softmax_cross_entropy_loss_grad.sv
verif/softmax_cross_entropy_loss_grad_tb.sv
